FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked outside reset.
`define SWG_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("swg assertion failed");

// Property checked on every edge, reset included.
`define SWG_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("swg assertion failed");

`endif

FILE: rtl/swg_pkg.sv
// ---------------------------------------------------------------------------
// swg_pkg
// Types and constants of the swing trajectory spline generator.
// ---------------------------------------------------------------------------
`default_nettype none

package swg_pkg;

  localparam int unsigned POS_W  = 16;
  localparam int unsigned COEF_W = 32;
  localparam int unsigned ACC_W  = 36;   // Horner accumulator
  localparam int unsigned MB_W   = 18;   // narrow multiplier operand
  localparam int unsigned PROD_W = ACC_W + MB_W;
  localparam int unsigned N_W    = 38;   // Hermite numerators
  localparam int unsigned NUM_W  = 54;   // divider dividend
  localparam int unsigned DEN_W  = 36;   // divider divisor
  localparam int unsigned CNT_W  = $clog2(NUM_W + 1);

  localparam logic [15:0] RATIO_RST  = 16'd32768;
  localparam logic [15:0] MID_RST    = 16'd49152;
  localparam logic [15:0] HEIGHT_RST = 16'd0;

  localparam logic [1:0] REG_RATIO  = 2'd0;
  localparam logic [1:0] REG_MID    = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  localparam logic [1:0] SEG_X  = 2'd0;
  localparam logic [1:0] SEG_Y  = 2'd1;
  localparam logic [1:0] SEG_ZR = 2'd2;
  localparam logic [1:0] SEG_ZF = 2'd3;

  localparam logic ACT_UPDATE = 1'b0;

  typedef enum logic [3:0] {
    OP_NONE, OP_FLOAD, OP_MUL1, OP_MUL2, OP_MUL3, OP_DIVA2, OP_DIVQ, OP_DIVA3,
    OP_FSTORE, OP_ELOAD, OP_EMUL, OP_EADD, OP_ESTORE, OP_OUT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] seg;
    logic [1:0] lane;
    logic [1:0] k;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } stat_t;

  typedef struct packed {
    logic                    start;
    logic signed [NUM_W-1:0] num;
    logic signed [DEN_W-1:0] den;
  } div_req_t;

endpackage

`default_nettype wire

FILE: rtl/swg_div.sv
// ---------------------------------------------------------------------------
// swg_div
// Radix-2 restoring signed divider, truncating, saturated to 32 bits.
// ---------------------------------------------------------------------------
`default_nettype none

module swg_div import swg_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire div_req_t                 req,
  output logic                          done,
  output logic signed [COEF_W-1:0]      res
);

  localparam logic [NUM_W-1:0] LIM_POS = NUM_W'(64'd2147483647);
  localparam logic [NUM_W-1:0] LIM_NEG = NUM_W'(64'd2147483648);
  localparam logic [COEF_W-1:0] MAX_V = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic [COEF_W-1:0] MIN_V = {1'b1, {(COEF_W-1){1'b0}}};

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] qr;
  logic [DEN_W-1:0] dm;
  logic [DEN_W-1:0] rem;
  logic             neg;
  logic             dzero;
  logic             npos;
  logic             nzero;

  logic [DEN_W+1:0] diff;
  logic [DEN_W-1:0] rem_next;
  logic             qbit;

  always_comb begin
    diff     = {1'b0, rem, qr[NUM_W-1]} - {2'b00, dm};
    qbit     = ~diff[DEN_W+1];
    rem_next = qbit ? diff[DEN_W-1:0] : {rem[DEN_W-2:0], qr[NUM_W-1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      qr    <= req.num[NUM_W-1] ? NUM_W'(-req.num) : NUM_W'(req.num);
      dm    <= req.den[DEN_W-1] ? DEN_W'(-req.den) : DEN_W'(req.den);
      rem   <= '0;
      neg   <= req.num[NUM_W-1] ^ req.den[DEN_W-1];
      dzero <= (req.den == '0);
      npos  <= ~req.num[NUM_W-1] && (req.num != '0);
      nzero <= (req.num != '0);
    end else if (busy) begin
      rem <= rem_next;
      qr  <= {qr[NUM_W-2:0], qbit};
    end
  end

  always_comb begin
    if (dzero) begin
      res = npos ? MAX_V : (nzero ? MIN_V : '0);
    end else if (!neg) begin
      res = (qr > LIM_POS) ? MAX_V : qr[COEF_W-1:0];
    end else begin
      res = (qr > LIM_NEG) ? MIN_V : COEF_W'(-qr[COEF_W-1:0]);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/swg_dp.sv
// ---------------------------------------------------------------------------
// swg_dp
// Datapath: config registers, shared multiplier, divider, coefficient store.
// ---------------------------------------------------------------------------
`default_nettype none

module swg_dp import swg_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_we,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [15:0]   cfg_data,
  input  wire logic          cap,
  input  wire logic [159:0]  in_data,
  input  wire cmd_t          cmd,
  output stat_t              stat,
  output logic [47:0]        out_data
);

  logic [15:0]  ratio;
  logic [15:0]  mid;
  logic [15:0]  height;
  logic [159:0] in_q;

  logic signed [15:0]       fx0, fx1;
  logic signed [16:0]       fs0, fs1;
  logic signed [MB_W-1:0]   fdur;
  logic signed [N_W-1:0]    n2, n3;
  logic signed [DEN_W-1:0]  t2;
  logic signed [COEF_W-1:0] a2;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [COEF_W-1:0] coef [16];
  logic signed [POS_W-1:0]  posw [3];
  logic signed [POS_W-1:0]  outq [3];

  logic signed [15:0] lx, ly, lz, tx, ty, tz, hgt;
  logic signed [16:0] nvx, nvy, nvz;
  logic [15:0]        ph;
  logic signed [MB_W-1:0] dur_t, dur_m, dur_f, et;
  logic [1:0]         eseg;
  logic signed [16:0] d;
  logic signed [N_W-1:0] d38;
  logic signed [N_W-1:0] prod38;
  logic signed [ACC_W-1:0]  ma;
  logic signed [MB_W-1:0]   mb;
  logic signed [PROD_W-1:0] mprod;
  div_req_t           dreq;
  logic               ddone;
  logic signed [COEF_W-1:0] dres;
  logic signed [15:0] sx0, sx1;
  logic signed [16:0] ss0, ss1;
  logic signed [MB_W-1:0] sdur;

  function automatic logic signed [POS_W-1:0] sat16(input logic signed [ACC_W-1:0] v);
    if (v > ACC_W'(32767))       sat16 = 16'sh7fff;
    else if (v < -ACC_W'(32768)) sat16 = 16'sh8000;
    else                         sat16 = v[POS_W-1:0];
  endfunction

  always_comb begin
    lx  = $signed(in_q[15:0]);
    ly  = $signed(in_q[31:16]);
    lz  = $signed(in_q[47:32]);
    tx  = $signed(in_q[63:48]);
    ty  = $signed(in_q[79:64]);
    tz  = $signed(in_q[95:80]);
    nvx = -17'($signed(in_q[111:96]));
    nvy = -17'($signed(in_q[127:112]));
    nvz = -17'($signed(in_q[143:128]));
    ph  = in_q[159:144];
    hgt = $signed(height);

    dur_t = 18'sd65536 - $signed({2'b00, ratio});
    dur_m = 18'sd65536 - $signed({2'b00, mid});
    dur_f = $signed({2'b00, mid}) - $signed({2'b00, ratio});

    // segment operand select
    case (cmd.seg)
      SEG_X:   begin sx0 = lx;  ss0 = nvx; sx1 = tx;  ss1 = nvx;  sdur = dur_t; end
      SEG_Y:   begin sx0 = ly;  ss0 = nvy; sx1 = ty;  ss1 = nvy;  sdur = dur_t; end
      SEG_ZR:  begin sx0 = lz;  ss0 = nvz; sx1 = hgt; ss1 = '0;   sdur = dur_m; end
      default: begin sx0 = hgt; ss0 = '0;  sx1 = tz;  ss1 = nvz;  sdur = dur_f; end
    endcase

    // z switches to the fall segment at the midpoint
    if (cmd.lane == SEG_ZR) eseg = (ph >= mid) ? SEG_ZF : SEG_ZR;
    else                    eseg = cmd.lane;
    et = (eseg == SEG_ZF) ? $signed({2'b00, ph}) - $signed({2'b00, mid})
                          : $signed({2'b00, ph}) - $signed({2'b00, ratio});

    d      = 17'(fx0) - 17'(fx1);
    d38    = N_W'(d);
    prod38 = prod[N_W-1:0];

    case (cmd.op)
      OP_MUL1: begin ma = ACC_W'(fs0) + ACC_W'(fs0) + ACC_W'(fs1); mb = fdur; end
      OP_MUL2: begin ma = ACC_W'(fs0) + ACC_W'(fs1);               mb = fdur; end
      OP_MUL3: begin ma = ACC_W'(fdur);                            mb = fdur; end
      default: begin ma = acc;                                     mb = et;   end
    endcase
    mprod = ma * mb;

    dreq.start = 1'b0;
    dreq.num   = NUM_W'(n3) <<< 16;
    dreq.den   = t2;
    case (cmd.op)
      OP_DIVA2: begin
        dreq.start = 1'b1;
        dreq.num   = -(NUM_W'(n2) <<< 16);
        dreq.den   = $signed(prod[DEN_W-1:0]);
      end
      OP_DIVQ: dreq.start = 1'b1;
      OP_DIVA3: begin
        dreq.start = 1'b1;
        dreq.num   = NUM_W'(dres) <<< 16;
        dreq.den   = DEN_W'(fdur);
      end
      default: dreq.start = 1'b0;
    endcase
  end

  swg_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (dreq),
    .done (ddone),
    .res  (dres)
  );

  assign stat.div_done = ddone;

  always_ff @(posedge clk) begin
    if (rst) begin
      ratio  <= RATIO_RST;
      mid    <= MID_RST;
      height <= HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RATIO:  ratio  <= cfg_data;
        REG_MID:    mid    <= cfg_data;
        REG_HEIGHT: height <= cfg_data;
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) coef[i] <= '0;
    end else if (cmd.op == OP_FSTORE) begin
      coef[{cmd.seg, 2'd0}] <= COEF_W'(fx0);
      coef[{cmd.seg, 2'd1}] <= COEF_W'(fs0);
      coef[{cmd.seg, 2'd2}] <= a2;
      coef[{cmd.seg, 2'd3}] <= dres;
    end
  end

  always_ff @(posedge clk) begin
    if (cap) in_q <= in_data;
    case (cmd.op)
      OP_FLOAD: begin
        fx0  <= sx0;
        fs0  <= ss0;
        fx1  <= sx1;
        fs1  <= ss1;
        fdur <= sdur;
      end
      OP_MUL1: prod <= mprod;
      OP_MUL2: begin
        n2   <= d38 * N_W'(3) * N_W'(65536) + prod38;
        prod <= mprod;
      end
      OP_MUL3: begin
        n3   <= d38 * N_W'(2) * N_W'(65536) + prod38;
        prod <= mprod;
      end
      OP_DIVA2: t2 <= $signed(prod[DEN_W-1:0]);
      OP_DIVQ:  a2 <= dres;
      OP_ELOAD: acc <= ACC_W'(coef[{eseg, 2'd3}]);
      OP_EMUL:  prod <= mprod;
      OP_EADD:  acc <= $signed(prod[ACC_W+15:16]) + ACC_W'(coef[{eseg, cmd.k}]);
      OP_ESTORE: posw[cmd.lane] <= sat16(acc);
      OP_OUT: begin
        outq[0] <= posw[0];
        outq[1] <= posw[1];
        outq[2] <= posw[2];
      end
      default: ;
    endcase
  end

  assign out_data = {outq[2], outq[1], outq[0]};

endmodule

`default_nettype wire

FILE: rtl/swg_ctrl.sv
// ---------------------------------------------------------------------------
// swg_ctrl
// Sequencer: fit of four segments on update, Horner steps on evaluate.
// ---------------------------------------------------------------------------
`default_nettype none

module swg_ctrl import swg_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  input  wire logic  in_action,
  output logic       in_ready,
  input  wire stat_t stat,
  output cmd_t       cmd,
  output logic       out_valid,
  input  wire logic  out_ready
);

  typedef enum logic [4:0] {
    S_IDLE, S_FLOAD, S_MUL1, S_MUL2, S_MUL3, S_DIVA2, S_W1, S_DIVQ, S_W2,
    S_DIVA3, S_W3, S_FSTORE, S_ELOAD, S_EMUL, S_EADD, S_ESTORE, S_EOUT
  } state_t;

  state_t     state;
  logic [1:0] seg;
  logic [1:0] lane;
  logic [1:0] k;
  logic       out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = ~out_valid | out_ready;

  always_comb begin
    cmd.seg  = seg;
    cmd.lane = lane;
    cmd.k    = k;
    case (state)
      S_FLOAD:  cmd.op = OP_FLOAD;
      S_MUL1:   cmd.op = OP_MUL1;
      S_MUL2:   cmd.op = OP_MUL2;
      S_MUL3:   cmd.op = OP_MUL3;
      S_DIVA2:  cmd.op = OP_DIVA2;
      S_DIVQ:   cmd.op = OP_DIVQ;
      S_DIVA3:  cmd.op = OP_DIVA3;
      S_FSTORE: cmd.op = OP_FSTORE;
      S_ELOAD:  cmd.op = OP_ELOAD;
      S_EMUL:   cmd.op = OP_EMUL;
      S_EADD:   cmd.op = OP_EADD;
      S_ESTORE: cmd.op = OP_ESTORE;
      S_EOUT:   cmd.op = out_free ? OP_OUT : OP_NONE;
      default:  cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      seg       <= '0;
      lane      <= '0;
      k         <= '0;
    end else begin
      // in S_EOUT the valid flag is set below when the register frees up
      if (out_valid && out_ready && state != S_EOUT) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            seg  <= SEG_X;
            lane <= SEG_X;
            state <= (in_action == ACT_UPDATE) ? S_FLOAD : S_ELOAD;
          end
        end
        S_FLOAD: state <= S_MUL1;
        S_MUL1:  state <= S_MUL2;
        S_MUL2:  state <= S_MUL3;
        S_MUL3:  state <= S_DIVA2;
        S_DIVA2: state <= S_W1;
        S_W1:    if (stat.div_done) state <= S_DIVQ;
        S_DIVQ:  state <= S_W2;
        S_W2:    if (stat.div_done) state <= S_DIVA3;
        S_DIVA3: state <= S_W3;
        S_W3:    if (stat.div_done) state <= S_FSTORE;
        S_FSTORE: begin
          if (seg == SEG_ZF) state <= S_IDLE;
          else begin
            seg   <= seg + 1'b1;
            state <= S_FLOAD;
          end
        end
        S_ELOAD: begin
          k     <= 2'd2;
          state <= S_EMUL;
        end
        S_EMUL: state <= S_EADD;
        S_EADD: begin
          if (k == 2'd0) state <= S_ESTORE;
          else begin
            k     <= k - 1'b1;
            state <= S_EMUL;
          end
        end
        S_ESTORE: begin
          if (lane == SEG_ZR) state <= S_EOUT;
          else begin
            lane  <= lane + 1'b1;
            state <= S_ELOAD;
          end
        end
        S_EOUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/swing_trajectory_cubic_spline_top.sv
// ---------------------------------------------------------------------------
// swing_trajectory_cubic_spline_top
// Update beat: s_tready returns after four segments (each of four
//   setup/multiply steps, three divides on the 54-step divider, one
//   store); it returns no beat.
// Evaluate beat: m_tvalid after three lanes of three multiply/add steps
//   on the shared multiplier; one beat in flight, the next beat is taken
//   once the result is in the output register, which waits on a stall.
// Reset (rst, synchronous): config to defaults, coefficients to zero.
// ---------------------------------------------------------------------------
`default_nettype none

module swing_trajectory_cubic_spline_top import swg_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [15:0]  cfg_data,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // liftoff_x, liftoff_y, liftoff_z, touchdown_x, touchdown_y, touchdown_z,
  // vel_x, vel_y, vel_z, phase_time
  input  wire logic [159:0] s_tdata,
  input  wire logic         s_tuser,   // action
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [47:0]       m_tdata    // pos_x, pos_y, pos_z
);

  cmd_t  cmd;
  stat_t stat;

  swg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_action (s_tuser),
    .in_ready  (s_tready),
    .stat      (stat),
    .cmd       (cmd),
    .out_valid (m_tvalid),
    .out_ready (m_tready)
  );

  swg_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cap       (s_tvalid & s_tready),
    .in_data   (s_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (m_tdata)
  );

endmodule

`default_nettype wire

FILE: rtl/swg_checker.sv
// ---------------------------------------------------------------------------
// swg_checker
// Port-level checks of the swing trajectory generator, bound to the top.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module swg_checker (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         s_tvalid,
  input wire logic         s_tready,
  input wire logic         m_tvalid,
  input wire logic         m_tready,
  input wire logic [47:0]  m_tdata
);

  `SWG_ASSERT(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid)
  `SWG_ASSERT(a_out_stable, clk, rst, m_tvalid && !m_tready |=> $stable(m_tdata))
  // one item at a time: busy right after a beat is taken
  `SWG_ASSERT(a_busy_after_accept, clk, rst, s_tvalid && s_tready |=> !s_tready)
  `SWG_ASSERT_ALWAYS(a_reset_clears_out, clk, rst |=> !m_tvalid)

endmodule

bind swing_trajectory_cubic_spline_top swg_checker u_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

FILE: tb/sv/testbench.sv
// ---------------------------------------------------------------------------
// Swing trajectory spline generator testbench
// Drives update and evaluate beats with random gaps and output stalls. It
// predicts every foot position from its own copy of the coefficients and
// the config, and checks each output beat field by field.
// ---------------------------------------------------------------------------
`default_nettype none

class trajectory_scoreboard;
  int unsigned ratio_q16;
  int unsigned mid_q16;
  logic signed [15:0] apex_z;
  int coef[16];
  logic [47:0] expected_pos[$];
  int errors;

  function new();
    ratio_q16 = 32768;
    mid_q16 = 49152;
    apex_z = 0;
    foreach (coef[i]) coef[i] = 0;
    errors = 0;
  endfunction

  function void write_reg(logic [1:0] idx, logic [15:0] val);
    if (idx == swg_pkg::REG_RATIO) ratio_q16 = val;
    else if (idx == swg_pkg::REG_MID) mid_q16 = val;
    else if (idx == swg_pkg::REG_HEIGHT) apex_z = val;
  endfunction

  function longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // divide by zero saturates on the numerator's sign
  function longint div_clamp(longint num, longint den);
    if (den == 0) begin
      if (num > 0) return 64'sd2147483647;
      if (num < 0) return -64'sd2147483648;
      return 0;
    end
    return clamp32(num / den);
  endfunction

  function void fit_segment(int seg, longint x0, longint s0, longint x1, longint s1,
                            longint dur);
    longint d, n2, n3, q;
    d = x0 - x1;
    n2 = 3 * d * 65536 + dur * (2 * s0 + s1);
    n3 = 2 * d * 65536 + dur * (s0 + s1);
    q = div_clamp(n3 * 65536, dur * dur);
    coef[seg*4 + 0] = int'(x0);
    coef[seg*4 + 1] = int'(s0);
    coef[seg*4 + 2] = int'(div_clamp(-n2 * 65536, dur * dur));
    coef[seg*4 + 3] = int'(div_clamp(q * 65536, dur));
  endfunction

  function logic [15:0] horner_pos(int seg, longint t);
    longint acc;
    acc = coef[seg*4 + 3];
    for (int k = 2; k >= 0; k--) acc = ((acc * t) >>> 16) + coef[seg*4 + k];
    if (acc > 32767) acc = 32767;
    if (acc < -32768) acc = -32768;
    return acc[15:0];
  endfunction

  function void note_beat(logic act, logic [159:0] d);
    longint dur, dur_m, vx, vy, vz, ph, t;
    logic [47:0] pos;
    if (act == swg_pkg::ACT_UPDATE) begin
      dur = 65536 - longint'(ratio_q16);
      dur_m = 65536 - longint'(mid_q16);
      vx = -longint'($signed(d[111:96]));
      vy = -longint'($signed(d[127:112]));
      vz = -longint'($signed(d[143:128]));
      fit_segment(swg_pkg::SEG_X, $signed(d[15:0]), vx, $signed(d[63:48]), vx, dur);
      fit_segment(swg_pkg::SEG_Y, $signed(d[31:16]), vy, $signed(d[79:64]), vy, dur);
      fit_segment(swg_pkg::SEG_ZR, $signed(d[47:32]), vz, apex_z, 0, dur_m);
      fit_segment(swg_pkg::SEG_ZF, apex_z, 0, $signed(d[95:80]), vz, dur - dur_m);
    end else begin
      ph = d[159:144];
      t = ph - longint'(ratio_q16);
      pos[15:0] = horner_pos(swg_pkg::SEG_X, t);
      pos[31:16] = horner_pos(swg_pkg::SEG_Y, t);
      if (ph < longint'(mid_q16)) pos[47:32] = horner_pos(swg_pkg::SEG_ZR, t);
      else pos[47:32] = horner_pos(swg_pkg::SEG_ZF, ph - longint'(mid_q16));
      expected_pos.push_back(pos);
    end
  endfunction

  function void check_pos(logic [47:0] got);
    logic [47:0] want;
    if (expected_pos.size() == 0) begin
      $display("%0t: unexpected output beat %h", $time, got);
      errors++;
      return;
    end
    want = expected_pos.pop_front();
    for (int f = 0; f < 3; f++)
      if (got[f*16 +: 16] !== want[f*16 +: 16]) begin
        $display("%0t: pos field %0d expected %0d got %0d", $time, f,
                 $signed(want[f*16 +: 16]), $signed(got[f*16 +: 16]));
        errors++;
      end
  endfunction
endclass

module testbench;
  import swg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam logic ACT_EVAL = 1'b1;

  logic clk, rst, cfg_we;
  logic [1:0] cfg_index;
  logic [15:0] cfg_data;
  logic s_tvalid, s_tready, s_tuser, m_tvalid, m_tready;
  logic [159:0] s_tdata;
  logic [47:0] m_tdata;

  logic no_idle, stall_req, stall_done;
  int stall_cnt;
  trajectory_scoreboard sb = new();

  swing_trajectory_cubic_spline_top u_top (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("testbench failed");
    $finish;
  end

  // input monitor
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) sb.note_beat(s_tuser, s_tdata);
  end

  // output side: check, then pick the next stall
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_cnt <= 0;
      stall_done <= 1'b0;
    end else if (stall_req && !stall_done) begin
      m_tready <= 1'b0;
      stall_cnt <= 400;
      stall_done <= 1'b1;
      if (m_tvalid && m_tready) sb.check_pos(m_tdata);
    end else if (m_tvalid && m_tready) begin
      sb.check_pos(m_tdata);
      if (!no_idle) begin
        stall_cnt <= $urandom_range(0, 9);
        m_tready <= 1'b0;
      end
    end else if (!m_tready) begin
      if (stall_cnt <= 1) m_tready <= 1'b1;
      else stall_cnt <= stall_cnt - 1;
    end
  end

  function automatic logic [15:0] rand_pos();
    case ($urandom_range(0, 4))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2, 3: return 16'($urandom_range(0, 8191) - 4096);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [159:0] rand_update();
    logic [159:0] d;
    for (int f = 0; f < 9; f++) d[f*16 +: 16] = rand_pos();
    d[159:144] = 16'($urandom);
    return d;
  endfunction

  task automatic send_beat(logic act, logic [159:0] d);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= act;
    s_tdata <= d;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_eval(logic [15:0] ph);
    logic [159:0] d;
    d = {ph, 144'(rand_update())};
    send_beat(ACT_EVAL, d);
  endtask

  // sender pause until every position is back, then the update settle time
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.expected_pos.size() != 0);
    repeat (800) @(posedge clk);
  endtask

  task automatic write_cfg(logic [15:0] ratio, logic [15:0] mid, logic [15:0] height);
    logic [1:0] idx[4];
    logic [15:0] val[4];
    idx = '{REG_RATIO, REG_MID, REG_HEIGHT, REG_UNUSED};
    val = '{ratio, mid, height, 16'($urandom)};
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      sb.write_reg(idx[i], val[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(int n);
    logic [15:0] ph;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0) send_beat(ACT_UPDATE, rand_update());
      else begin
        ph = ($urandom_range(0, 3) == 0) ? 16'($urandom)
           : 16'(sb.ratio_q16 + $urandom_range(0, 65535 - sb.ratio_q16));
        send_eval(ph);
      end
    end
  endtask

  initial begin
    logic [15:0] ratio, mid;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_RATIO;
    cfg_data <= '0;
    s_tvalid <= 1'b0;
    s_tuser <= ACT_UPDATE;
    s_tdata <= '0;
    no_idle <= 1'b0;
    stall_req <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // evaluate before any update gives zeros
    send_eval(16'd0);
    send_eval(16'hFFFF);
    send_beat(ACT_UPDATE, {16'd0, {9{16'h7FFF}}});
    send_eval(16'd0);
    send_eval(16'd32768);
    send_eval(16'd49151);
    send_eval(16'd49152);
    send_eval(16'hFFFF);
    send_beat(ACT_UPDATE, {16'hFFFF, {9{16'h8000}}});
    send_eval(16'd0);
    send_eval(16'd40000);
    send_eval(16'hFFFF);
    send_beat(ACT_UPDATE, {16'd0, {3{16'h0800}}, {3{16'hF000}}, {3{16'h1000}}});
    send_eval(16'd36000);
    send_eval(16'd60000);
    drain();

    // ratio equal to midpoint: zero-length fall, apex at the positive limit
    write_cfg(16'd0, 16'd0, 16'h7FFF);
    send_beat(ACT_UPDATE, rand_update());
    send_eval(16'd0);
    send_eval(16'hFFFF);
    random_phase(55);
    drain();

    // shortest swing, apex at the negative limit
    write_cfg(16'hFFFF, 16'hFFFF, 16'h8000);
    random_phase(55);
    drain();

    // midpoint before ratio: negative fall duration; no idling here
    no_idle <= 1'b1;
    write_cfg(16'hC000, 16'h8000, 16'h0400);
    random_phase(55);
    drain();
    no_idle <= 1'b0;

    // long output stall while evaluates keep coming
    write_cfg(16'h8000, 16'hC000, 16'($urandom));
    send_beat(ACT_UPDATE, rand_update());
    stall_req <= 1'b1;
    no_idle <= 1'b1;
    for (int i = 0; i < 12; i++) send_eval(16'($urandom));
    no_idle <= 1'b0;
    random_phase(45);
    drain();

    for (int p = 0; p < 4; p++) begin
      ratio = 16'($urandom);
      mid = (p == 0) ? ratio : 16'($urandom_range(ratio, 65535));
      write_cfg(ratio, mid, rand_pos());
      random_phase(55);
      drain();
    end

    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.expected_pos.size() == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end
endmodule

`default_nettype wire
